/* rtl/core/first_fit_block_allocator_core_macros.svh */
// Assertion macros for the first-fit block allocator core.
// Used by files under rtl/core; expects clock and reset in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by ffba_arena and the top level.
`default_nettype none

package ffba_pkg;

   localparam int DEFAULT_CELLS   = 128;
   localparam int DEFAULT_ID_BITS = 16;

   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 8;

   localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEFRAG = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd2;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_READ,
      FSM_CHECK,
      FSM_FILL,
      FSM_ZERO,
      FSM_RESP
   } ffba_state_type;

   // control of the single arena port
   typedef struct packed {
      logic en;
      logic we;
   } ffba_mem_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/ffba_arena.sv */
// Single-port arena store: one read or one write per cycle, registered read data.
// Depends on ffba_pkg for the port control struct.
`default_nettype none

module ffba_arena
   import ffba_pkg::*;
#(
   parameter int DEPTH = DEFAULT_CELLS,
   parameter int AW    = 7,
   parameter int DW    = DEFAULT_ID_BITS
) (
   input  wire logic             clock,
   input  wire ffba_mem_ctl_type ctl,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [DW-1:0]    wdata,
   output logic      [DW-1:0]    rdata
);

   logic [DW-1:0] cells_mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         if (ctl.we) begin
            cells_mem[addr] <= wdata;
         end else begin
            rdata_ff <= cells_mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/first_fit_block_allocator_core.sv */
// Scans are bounded by L = min(cells_in_use, CELLS); early rejects and other kinds go
// straight to the result. One request in work at a time; the next is taken the cycle
// after its result is loaded. Each arena cell passes through a read state and a compare/write
// state on the single-port arena. Reset (synchronous) starts a clearing pass over all CELLS
// arena cells; requests stall until it ends, csr writes are taken throughout.
`default_nettype none
`include "first_fit_block_allocator_core_macros.svh"

module first_fit_block_allocator_core
   import ffba_pkg::*;
#(
   parameter int CELLS   = DEFAULT_CELLS,
   parameter int ID_BITS = DEFAULT_ID_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [SIZE_W-1:0]   req_alloc_size,
   input  wire logic [ID_BITS-1:0]  req_erase_id,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [ID_BITS-1:0]  rsp_block_id,
   // register write channel
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CFG_W-1:0]    csr_cells_in_use
);

   localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW = $clog2(CELLS + 1);
   localparam int LW = (CW > CFG_W) ? CW : CFG_W;

   ffba_state_type state_ff, state_in;

   logic [CFG_W-1:0]    csr_ff, csr_in;
   logic [ID_BITS:0]    next_id_ff, next_id_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       wr_ff, wr_in;
   logic [CW-1:0]       run_ff, run_in;
   logic                hit_ff, hit_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ID_BITS-1:0]  key_ff, key_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [ID_BITS-1:0]  pend_id_ff, pend_id_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]  rsp_block_id_ff, rsp_block_id_in;

   ffba_mem_ctl_type    mem_ctl;
   logic [AW-1:0]       mem_addr;
   logic [ID_BITS-1:0]  mem_wdata;
   logic [ID_BITS-1:0]  mem_rdata;

   logic [LW-1:0]       lim_wide;
   logic [CW-1:0]       lim;
   logic                accept;
   logic                rsp_free;
   logic                cell_match;
   logic [CW-1:0]       run_inc;
   logic                run_hit;
   logic                id_exhausted;

   ffba_arena #(
      .DEPTH (CELLS),
      .AW    (AW),
      .DW    (ID_BITS)
   ) u_arena (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // register values above CELLS count as CELLS
   assign lim_wide = (LW'(csr_ff) > LW'(CELLS)) ? LW'(CELLS) : LW'(csr_ff);
   assign lim      = lim_wide[CW-1:0];

   assign accept       = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign id_exhausted = next_id_ff[ID_BITS];

   // the shared cell comparator: free-cell test for alloc/defragment, id test for erase
   assign cell_match = (mem_rdata == key_ff);
   assign run_inc    = run_ff + CW'(1);
   assign run_hit    = (LW'(run_inc) >= LW'(size_ff));

   assign csr_ready = 1'b1;
   assign csr_in    = (csr_valid && csr_ready) ? csr_cells_in_use : csr_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (idx_ff == CW'(CELLS - 1)) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_ALLOC: begin
                     if (req_alloc_size == '0 || id_exhausted) state_in = FSM_RESP;
                     else state_in = FSM_READ;
                  end
                  KIND_ERASE: begin
                     if (req_erase_id == '0) state_in = FSM_RESP;
                     else state_in = FSM_READ;
                  end
                  KIND_DEFRAG: state_in = FSM_READ;
                  default:     state_in = FSM_RESP;
               endcase
            end
         end
         FSM_READ: begin
            if (idx_ff == lim) begin
               state_in = (kind_ff == KIND_DEFRAG) ? FSM_ZERO : FSM_RESP;
            end else begin
               state_in = FSM_CHECK;
            end
         end
         FSM_CHECK: begin
            if (kind_ff == KIND_ALLOC && cell_match && run_hit) state_in = FSM_FILL;
            else state_in = FSM_READ;
         end
         FSM_FILL: begin
            if (wr_ff == idx_ff) state_in = FSM_RESP;
         end
         FSM_ZERO: begin
            if (wr_ff == lim) state_in = FSM_RESP;
         end
         FSM_RESP: begin
            if (rsp_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_CLEAR;
      endcase
   end

   // outputs: request stall and arena port
   always_comb begin
      req_stall  = 1'b1;
      mem_ctl    = '0;
      mem_addr   = idx_ff[AW-1:0];
      mem_wdata  = '0;
      unique case (state_ff)
         FSM_CLEAR: begin
            mem_ctl = '{en: 1'b1, we: 1'b1};
         end
         FSM_IDLE: begin
            req_stall = 1'b0;
         end
         FSM_READ: begin
            if (idx_ff != lim) mem_ctl = '{en: 1'b1, we: 1'b0};
         end
         FSM_CHECK: begin
            if (kind_ff == KIND_ERASE && cell_match) begin
               mem_ctl = '{en: 1'b1, we: 1'b1};
            end else if (kind_ff == KIND_DEFRAG && !cell_match) begin
               // wr never passes idx, so this cell was already read
               mem_ctl   = '{en: 1'b1, we: 1'b1};
               mem_addr  = wr_ff[AW-1:0];
               mem_wdata = mem_rdata;
            end
         end
         FSM_FILL: begin
            mem_ctl   = '{en: 1'b1, we: 1'b1};
            mem_addr  = wr_ff[AW-1:0];
            mem_wdata = next_id_ff[ID_BITS-1:0];
         end
         FSM_ZERO: begin
            if (wr_ff != lim) begin
               mem_ctl  = '{en: 1'b1, we: 1'b1};
               mem_addr = wr_ff[AW-1:0];
            end
         end
         FSM_RESP: ;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      next_id_in      = next_id_ff;
      idx_in          = idx_ff;
      wr_in           = wr_ff;
      run_in          = run_ff;
      hit_in          = hit_ff;
      kind_in         = kind_ff;
      size_in         = size_ff;
      key_in          = key_ff;
      pend_status_in  = pend_status_ff;
      pend_id_in      = pend_id_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_block_id_in = rsp_block_id_ff;

      case (state_ff)
         FSM_CLEAR: begin
            idx_in = idx_ff + CW'(1);
         end
         FSM_IDLE: begin
            if (accept) begin
               kind_in        = req_kind;
               size_in        = req_alloc_size;
               key_in         = (req_kind == KIND_ERASE) ? req_erase_id : '0;
               idx_in         = '0;
               wr_in          = '0;
               run_in         = '0;
               hit_in         = 1'b0;
               pend_id_in     = '0;
               pend_status_in = STATUS_OK;
               if (req_kind == KIND_ALLOC && (req_alloc_size == '0 || id_exhausted)) begin
                  pend_status_in = STATUS_NOSPACE;
               end
               if (req_kind == KIND_ERASE && req_erase_id == '0) begin
                  pend_status_in = STATUS_ILLEGAL;
               end
            end
         end
         FSM_READ: begin
            if (idx_ff == lim) begin
               if (kind_ff == KIND_ALLOC) pend_status_in = STATUS_NOSPACE;
               else if (kind_ff == KIND_ERASE && !hit_ff) pend_status_in = STATUS_ILLEGAL;
            end
         end
         FSM_CHECK: begin
            idx_in = idx_ff + CW'(1);
            if (kind_ff == KIND_ALLOC) begin
               if (cell_match) begin
                  if (run_ff == '0) wr_in = idx_ff;
                  run_in = run_inc;
                  // run complete: keep idx as the last cell to fill
                  if (run_hit) idx_in = idx_ff;
               end else begin
                  run_in = '0;
               end
            end else if (kind_ff == KIND_ERASE) begin
               if (cell_match) hit_in = 1'b1;
            end else begin
               if (!cell_match) wr_in = wr_ff + CW'(1);
            end
         end
         FSM_FILL: begin
            if (wr_ff == idx_ff) begin
               next_id_in     = next_id_ff + (ID_BITS+1)'(1);
               pend_status_in = STATUS_OK;
               pend_id_in     = next_id_ff[ID_BITS-1:0];
            end else begin
               wr_in = wr_ff + CW'(1);
            end
         end
         FSM_ZERO: begin
            if (wr_ff != lim) wr_in = wr_ff + CW'(1);
         end
         FSM_RESP: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = pend_status_ff;
               rsp_block_id_in = pend_id_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         idx_ff       <= '0;
         next_id_ff   <= (ID_BITS+1)'(1);
         csr_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         next_id_ff   <= next_id_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ff           <= wr_in;
      run_ff          <= run_in;
      hit_ff          <= hit_in;
      kind_ff         <= kind_in;
      size_ff         <= size_in;
      key_ff          <= key_in;
      pend_status_ff  <= pend_status_in;
      pend_id_ff      <= pend_id_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_block_id_ff <= rsp_block_id_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_block_id = rsp_block_id_ff;

   `FFBA_ASSERT_NOW(a_defrag_wr_behind_rd,
      (state_ff == FSM_CHECK && kind_ff == KIND_DEFRAG), (wr_ff <= idx_ff),
      "defragment write pointer passed read pointer")
   `FFBA_ASSERT_NOW(a_fill_id_available, (state_ff == FSM_FILL), (!id_exhausted),
      "arena fill with exhausted identifier counter")
   `FFBA_ASSERT_NOW(a_write_below_limit,
      (mem_ctl.en && mem_ctl.we && state_ff != FSM_CLEAR), (CW'(mem_addr) < lim),
      "arena write at or beyond the usable limit")
   `FFBA_ASSERT_NEXT(a_read_then_check, (mem_ctl.en && !mem_ctl.we), (state_ff == FSM_CHECK),
      "arena read not followed by a compare cycle")

endmodule

`default_nettype wire
